>>> src/ggvc_pkg.sv
// Package for the go-to-goal velocity controller: shared widths, the arctangent
// table, register indexes and the structs passed between the pipeline modules.
// Depends on nothing; every other file of the block imports it.
package ggvc_pkg;

  // Widths of the datapath.
  localparam int COORD_W   = 12;
  localparam int DELTA_W   = 13;
  localparam int HEAD_W    = 11;
  localparam int SQR_W     = 24;   // one squared difference
  localparam int SQ_W      = 25;   // sum of squares
  localparam int DIST_W    = 13;   // integer square root of the sum
  localparam int XY_W      = 32;   // CORDIC vector components
  localparam int Z_W       = 34;   // CORDIC angle accumulator, Q.30 radians
  localparam int GAIN_W    = 10;
  localparam int STOP_W    = 12;
  localparam int SPEED_W   = 15;
  localparam int TURN_W    = 16;
  localparam int CORDIC_SHIFT = 16;

  // The square root takes one result bit per step.
  localparam int SQRT_STEPS   = 13;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;

  // atan(2^-i) in Q.30, truncated.
  localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  typedef enum logic [1:0] {
    REG_STOP_DISTANCE = 2'd0,
    REG_LINEAR_GAIN   = 2'd1,
    REG_ANGULAR_GAIN  = 2'd2
  } cfg_reg_e;

  // Payload carried along the row of cells.
  typedef struct packed {
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
    logic [SQ_W-1:0]          rem;
    logic [SQ_W-1:0]          root;
    logic                     moving;
    logic signed [HEAD_W-1:0] hd;
  } cell_t;

  typedef struct packed {
    logic [GAIN_W-1:0] linear;
    logic [GAIN_W-1:0] angular;
  } gains_t;

endpackage

>>> src/go_to_goal_velocity_controller_unit.sv
// Top level of the go-to-goal velocity controller: front end, row of cells,
// output scaling and the configuration registers. Depends on ggvc_pkg,
// ggvc_cell and ggvc_scale.
//
// Usage. Each input transfer carries the goal and current positions (unsigned
// Q4.8) and the heading (signed Q3.8). Each one yields exactly one output
// transfer with the forward speed, the turn rate and the moving flag, in order.
// Both channels use valid and ready; a transfer happens at a rising edge with
// both high.
// The item passes three front-end registers, one register per cell and three
// scaling registers. The row has max(min(CORDIC_STAGES, 24), 13) cells, since
// the square root needs thirteen result bits. Every stage is a register with
// its own valid bit, so one item can enter in every cycle while the receiver
// takes results. When the receiver stalls, the output register holds its
// result and the stages behind it keep loading until each one is full; only
// then does in_ready_o fall. No item is lost or duplicated.
// Reset clears all valid bits and loads the register defaults (stop distance
// 128, linear gain 51, angular gain 307). The configuration port writes one
// register per cycle with cfg_we_i; an unknown index is ignored. The user must
// see that registers are written only while the block holds no items; the
// block itself does not enforce this.
module go_to_goal_velocity_controller_unit #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ggvc_pkg::COORD_W-1:0]        goal_x_i,
  input  logic [ggvc_pkg::COORD_W-1:0]        goal_y_i,
  input  logic [ggvc_pkg::COORD_W-1:0]        pose_x_i,
  input  logic [ggvc_pkg::COORD_W-1:0]        pose_y_i,
  input  logic signed [ggvc_pkg::HEAD_W-1:0]  heading_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ggvc_pkg::SPEED_W-1:0]        forward_speed_o,
  output logic signed [ggvc_pkg::TURN_W-1:0]  turn_rate_o,
  output logic                                moving_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [ggvc_pkg::STOP_W-1:0]         cfg_data_i
);
  import ggvc_pkg::*;

  // The arctangent table bounds the number of CORDIC steps; the square root
  // needs its own fixed number of steps, so the row is as long as the larger.
  localparam int STAGES  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int N_CELLS = (STAGES > SQRT_STEPS) ? STAGES : SQRT_STEPS;

  // Configuration registers. The squared threshold is kept in a register of
  // its own so that the multiplier stays out of the compare path.
  logic [STOP_W-1:0] stop_q;
  logic [GAIN_W-1:0] lin_q;
  logic [GAIN_W-1:0] ang_q;
  logic [SQR_W-1:0]  stop_sq_q;
  gains_t            gains;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q    <= STOP_W'(128);
      lin_q     <= GAIN_W'(51);
      ang_q     <= GAIN_W'(307);
      stop_sq_q <= SQR_W'(16384);
    end else begin
      stop_sq_q <= {{STOP_W{1'b0}}, stop_q} * {{STOP_W{1'b0}}, stop_q};
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_STOP_DISTANCE: stop_q <= cfg_data_i;
          REG_LINEAR_GAIN:   lin_q  <= cfg_data_i[GAIN_W-1:0];
          REG_ANGULAR_GAIN:  ang_q  <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign gains.linear  = lin_q;
  assign gains.angular = ang_q;

  // Handshake and data links of the row of cells; link 0 is fed by the front end.
  logic  cell_v   [N_CELLS+1];
  logic  cell_rdy [N_CELLS+1];
  cell_t cell_d   [N_CELLS+1];

  // Front end. Stage one forms the differences, stage two the squares and the
  // starting CORDIC vector (folded into the right half-plane, with the
  // accumulator preset to plus or minus pi), stage three the sum of squares
  // and the threshold test.
  logic s1_v_q, s2_v_q, s3_v_q;
  logic ld1, ld2, ld3;

  logic signed [DELTA_W-1:0] dx_q, dy_q;
  logic signed [HEAD_W-1:0]  hd1_q, hd2_q;
  logic signed [2*DELTA_W-1:0] dx2_full, dy2_full;
  logic signed [XY_W-1:0]    dxw, dyw;
  logic signed [XY_W-1:0]    x0_d, y0_d, x0_q, y0_q;
  logic signed [Z_W-1:0]     z0_d, z0_q;
  logic [SQR_W-1:0]          dx2_q, dy2_q;
  logic [SQ_W-1:0]           sq;
  cell_t                     s3_d, s3_q;

  assign ld3 = !s3_v_q || cell_rdy[0];
  assign ld2 = !s2_v_q || ld3;
  assign ld1 = !s1_v_q || ld2;
  assign in_ready_o = ld1;

  always_comb begin
    dx2_full = dx_q * dx_q;
    dy2_full = dy_q * dy_q;
    dxw = XY_W'(dx_q) <<< CORDIC_SHIFT;
    dyw = XY_W'(dy_q) <<< CORDIC_SHIFT;
    if (dx_q < 0) begin
      x0_d = -dxw;
      y0_d = -dyw;
      z0_d = (dy_q >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      x0_d = dxw;
      y0_d = dyw;
      z0_d = '0;
    end
  end

  always_comb begin
    sq          = {1'b0, dx2_q} + {1'b0, dy2_q};
    s3_d.x      = x0_q;
    s3_d.y      = y0_q;
    s3_d.z      = z0_q;
    s3_d.rem    = sq;
    s3_d.root   = '0;
    s3_d.moving = sq > {1'b0, stop_sq_q};
    s3_d.hd     = hd2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (ld1) s1_v_q <= in_valid_i;
      if (ld2) s2_v_q <= s1_v_q;
      if (ld3) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1 && in_valid_i) begin
      dx_q  <= $signed({1'b0, goal_x_i}) - $signed({1'b0, pose_x_i});
      dy_q  <= $signed({1'b0, goal_y_i}) - $signed({1'b0, pose_y_i});
      hd1_q <= heading_i;
    end
    if (ld2 && s1_v_q) begin
      dx2_q <= dx2_full[SQR_W-1:0];
      dy2_q <= dy2_full[SQR_W-1:0];
      x0_q  <= x0_d;
      y0_q  <= y0_d;
      z0_q  <= z0_d;
      hd2_q <= hd1_q;
    end
    if (ld3 && s2_v_q) begin
      s3_q <= s3_d;
    end
  end

  // Row of cells: cell i does CORDIC step i and square root step i where
  // those exist, and hands its vector, angle and partial root to cell i+1.
  assign cell_v[0] = s3_v_q;
  assign cell_d[0] = s3_q;

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    ggvc_cell #(
      .IDX       (i),
      .CORDIC_ON (i < STAGES),
      .SQRT_ON   (i < SQRT_STEPS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cell_v[i]),
      .in_ready_o  (cell_rdy[i]),
      .in_data_i   (cell_d[i]),
      .out_valid_o (cell_v[i+1]),
      .out_ready_i (cell_rdy[i+1]),
      .out_data_o  (cell_d[i+1])
    );
  end

  ggvc_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .gains_i         (gains),
    .in_valid_i      (cell_v[N_CELLS]),
    .in_ready_o      (cell_rdy[N_CELLS]),
    .in_data_i       (cell_d[N_CELLS]),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .forward_speed_o (forward_speed_o),
    .turn_rate_o     (turn_rate_o),
    .moving_o        (moving_o)
  );

  // A result that is not moving must carry zero commands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !moving_o) |-> (forward_speed_o == '0 && turn_rate_o == '0))
    else $error("stopped result carries a non-zero command");

  // An empty first stage must always be able to take an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> in_ready_o)
    else $error("input refused while the first stage is empty");

  // The squared threshold follows a write of the stop distance via stop_q.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == REG_STOP_DISTANCE) |=> ##1
      (stop_sq_q == {{STOP_W{1'b0}}, $past(cfg_data_i, 2)}
                    * {{STOP_W{1'b0}}, $past(cfg_data_i, 2)}))
    else $error("squared stop distance out of step with the register");

endmodule

>>> src/ggvc_cell.sv
// One cell of the row: a CORDIC vectoring step and a square root step, each
// enabled by parameter, behind a valid/ready register. Depends on ggvc_pkg.
module ggvc_cell #(
  parameter int IDX       = 0,
  parameter bit CORDIC_ON = 1'b1,
  parameter bit SQRT_ON   = 1'b1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ggvc_pkg::cell_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ggvc_pkg::cell_t out_data_o
);
  import ggvc_pkg::*;

  localparam int SQ_SHIFT = SQRT_ON ? 2 * (SQRT_STEPS - 1 - IDX) : 0;
  localparam int ATAN_IDX = (IDX < ATAN_ENTRIES) ? IDX : ATAN_ENTRIES - 1;
  localparam logic [SQ_W:0] SQ_BIT = (SQ_W + 1)'(1) << SQ_SHIFT;
  localparam logic signed [Z_W-1:0] ATAN_K = $signed({4'b0, ATAN_Q30[ATAN_IDX]});

  logic             valid_q;
  cell_t            data_q;
  cell_t            data_d;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic [SQ_W:0]    trial;

  always_comb begin
    data_d = in_data_i;
    xs     = in_data_i.x >>> IDX;
    ys     = in_data_i.y >>> IDX;
    trial  = {1'b0, in_data_i.root} + SQ_BIT;
    if (CORDIC_ON) begin
      if (in_data_i.y > 0) begin
        data_d.x = in_data_i.x + ys;
        data_d.y = in_data_i.y - xs;
        data_d.z = in_data_i.z + ATAN_K;
      end else if (in_data_i.y < 0) begin
        data_d.x = in_data_i.x - ys;
        data_d.y = in_data_i.y + xs;
        data_d.z = in_data_i.z - ATAN_K;
      end
    end
    if (SQRT_ON) begin
      if ({1'b0, in_data_i.rem} >= trial) begin
        data_d.rem  = in_data_i.rem - trial[SQ_W-1:0];
        data_d.root = (in_data_i.root >> 1) + SQ_BIT[SQ_W-1:0];
      end else begin
        data_d.root = in_data_i.root >> 1;
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> src/ggvc_scale.sv
// Output scaling: rounds the bearing, applies both gains, rounds and saturates
// the commands, and holds the result register. Depends on ggvc_pkg.
module ggvc_scale #(
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ggvc_pkg::gains_t               gains_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ggvc_pkg::cell_t                in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ggvc_pkg::SPEED_W-1:0]   forward_speed_o,
  output logic signed [ggvc_pkg::TURN_W-1:0] turn_rate_o,
  output logic                           moving_o
);
  import ggvc_pkg::*;

  localparam int BW  = FRAC_BITS + 4;
  localparam int DW  = ((BW > HEAD_W) ? BW : HEAD_W) + 1;
  localparam int PW  = DW + GAIN_W + 1;
  localparam int TW  = PW + 1;
  localparam int SPW = GAIN_W + DIST_W;
  localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(1) << (29 - FRAC_BITS);
  localparam logic [SPW:0]          S_HALF = (SPW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [TW-1:0]  T_HALF = TW'(1) << (FRAC_BITS - 1);
  localparam logic signed [TW-1:0]  T_MAX  = TW'(32767);
  localparam logic signed [TW-1:0]  T_MIN  = -TW'(32768);

  logic v1_q, v2_q, v3_q;
  logic ld1, ld2, ld3;

  logic signed [Z_W-1:0]  z_rnd;
  logic signed [Z_W-1:0]  z_shr;
  logic signed [BW-1:0]   bearing;
  logic signed [DW-1:0]   diff_d, diff_q;
  logic [SPW-1:0]         sprod_d, sprod_q;
  logic                   mov1_q, mov2_q;

  logic signed [PW-1:0]   tprod_d, tprod_q;
  logic [SPW:0]           s_rnd;
  logic [SPW:0]           s_shr;
  logic [SPEED_W-1:0]     speed_d, speed2_q;

  logic signed [TW-1:0]   t_rnd;
  logic signed [TW-1:0]   t_shr;
  logic signed [TURN_W-1:0] turn_d;
  logic [SPEED_W-1:0]     speed_q;
  logic signed [TURN_W-1:0] turn_q;
  logic                   mov3_q;

  assign ld3 = !v3_q || out_ready_i;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign in_ready_o = ld1;

  // First step: bearing rounded to the output format, heading error, speed product.
  always_comb begin
    z_rnd   = in_data_i.z + Z_HALF;
    z_shr   = z_rnd >>> (30 - FRAC_BITS);
    bearing = z_shr[BW-1:0];
    diff_d  = DW'(bearing) - DW'(in_data_i.hd);
    sprod_d = {{DIST_W{1'b0}}, gains_i.linear} * {{GAIN_W{1'b0}}, in_data_i.root[DIST_W-1:0]};
  end

  // Second step: turn product, speed rounded and clipped.
  always_comb begin
    tprod_d = $signed({1'b0, gains_i.angular}) * diff_q;
    s_rnd   = {1'b0, sprod_q} + S_HALF;
    s_shr   = s_rnd >> FRAC_BITS;
    if (s_shr > (SPW + 1)'(32767)) begin
      speed_d = '1;
    end else begin
      speed_d = s_shr[SPEED_W-1:0];
    end
  end

  // Third step: turn rate rounded towards minus infinity after the half bias, clipped.
  always_comb begin
    t_rnd = TW'(tprod_q) + T_HALF;
    t_shr = t_rnd >>> FRAC_BITS;
    if (t_shr > T_MAX) begin
      turn_d = T_MAX[TURN_W-1:0];
    end else if (t_shr < T_MIN) begin
      turn_d = T_MIN[TURN_W-1:0];
    end else begin
      turn_d = t_shr[TURN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1 && in_valid_i) begin
      diff_q  <= diff_d;
      sprod_q <= sprod_d;
      mov1_q  <= in_data_i.moving;
    end
    if (ld2 && v1_q) begin
      tprod_q  <= tprod_d;
      speed2_q <= speed_d;
      mov2_q   <= mov1_q;
    end
    if (ld3 && v2_q) begin
      speed_q <= mov2_q ? speed2_q : '0;
      turn_q  <= mov2_q ? turn_d : '0;
      mov3_q  <= mov2_q;
    end
  end

  assign out_valid_o     = v3_q;
  assign forward_speed_o = speed_q;
  assign turn_rate_o     = turn_q;
  assign moving_o        = mov3_q;

endmodule

>>> bench/ggvc_checker.sv
`timescale 1ns / 1ps
// Checker for the go-to-goal velocity controller: watches the input, output and
// register-write ports, predicts every command and compares it with the block's.
// Depends on ggvc_pkg for the port widths and the register indexes.
module ggvc_checker #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [ggvc_pkg::COORD_W-1:0]        goal_x_i,
  input  logic [ggvc_pkg::COORD_W-1:0]        goal_y_i,
  input  logic [ggvc_pkg::COORD_W-1:0]        pose_x_i,
  input  logic [ggvc_pkg::COORD_W-1:0]        pose_y_i,
  input  logic signed [ggvc_pkg::HEAD_W-1:0]  heading_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [ggvc_pkg::SPEED_W-1:0]        forward_speed_i,
  input  logic signed [ggvc_pkg::TURN_W-1:0]  turn_rate_i,
  input  logic                                moving_i,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [ggvc_pkg::STOP_W-1:0]         cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import ggvc_pkg::*;

  localparam int     ANGLE_FRAC    = 30;
  localparam int     ARCTAN_COUNT  = 24;
  localparam longint HALF_TURN_Q30 = 64'sd3373259426;
  localparam longint SPEED_MAX     = 32767;
  localparam longint TURN_MAX      = 32767;
  localparam longint TURN_MIN      = -32768;

  // atan(2^-i) in Q.30 radians, truncated.
  localparam longint ARCTAN_Q30 [ARCTAN_COUNT] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686,  33543515,  16775850,  8388437,
    4194282,   2097149,   1048575,   524287,
    262143,    131071,    65535,     32767,
    16383,     8191,      4095,      2047,
    1023,      511,       255,       127
  };

  typedef struct packed {
    logic [SPEED_W-1:0]       speed;
    logic signed [TURN_W-1:0] turn;
    logic                     moving;
  } command_t;

  logic [STOP_W-1:0] stop_dist_q;
  logic [GAIN_W-1:0] lin_gain_q;
  logic [GAIN_W-1:0] ang_gain_q;
  command_t          commands_due [$];
  int                failures;

  function automatic command_t predict_command(
    logic [COORD_W-1:0] gx, logic [COORD_W-1:0] gy,
    logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
    logic signed [HEAD_W-1:0] hd);
    command_t cmd;
    longint   dx, dy, sum_sq, rem, root, bit_w;
    longint   x, y, z, xs, ys, speed, bearing, turn;
    int       stages;
    cmd    = '0;
    dx     = longint'(gx) - longint'(px);
    dy     = longint'(gy) - longint'(py);
    sum_sq = dx * dx + dy * dy;
    // At or inside the stop circle everything is zero; the comparison is exact.
    if (sum_sq <= longint'(stop_dist_q) * longint'(stop_dist_q)) return cmd;

    // Integer square root, floor.
    rem   = sum_sq;
    root  = 0;
    bit_w = 64'sd1 <<< 30;
    while (bit_w > rem) bit_w = bit_w >>> 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem  = rem - (root + bit_w);
        root = (root >>> 1) + bit_w;
      end else begin
        root = root >>> 1;
      end
      bit_w = bit_w >>> 2;
    end
    speed = (longint'(lin_gain_q) * root + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (speed > SPEED_MAX) speed = SPEED_MAX;

    // Bearing by CORDIC vectoring; vectors in the left half-plane are turned
    // round first, with the accumulator starting at plus or minus pi.
    z = 0;
    if (dx != 0 || dy != 0) begin
      x = dx * 65536;
      y = dy * 65536;
      if (x < 0) begin
        z = (y >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
        x = -x;
        y = -y;
      end
      stages = (CORDIC_STAGES > ARCTAN_COUNT) ? ARCTAN_COUNT : CORDIC_STAGES;
      for (int i = 0; i < stages; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ARCTAN_Q30[i];
        end else if (y < 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ARCTAN_Q30[i];
        end
      end
    end
    bearing = (z + (64'sd1 <<< (ANGLE_FRAC - FRAC_BITS - 1))) >>> (ANGLE_FRAC - FRAC_BITS);
    turn = (longint'(ang_gain_q) * (bearing - longint'(hd)) + (64'sd1 <<< (FRAC_BITS - 1)))
           >>> FRAC_BITS;
    if (turn > TURN_MAX) turn = TURN_MAX;
    if (turn < TURN_MIN) turn = TURN_MIN;

    cmd.speed  = speed[SPEED_W-1:0];
    cmd.turn   = turn[TURN_W-1:0];
    cmd.moving = 1'b1;
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    command_t got;
    command_t want;
    if (!rst_ni) begin
      commands_due.delete();
      stop_dist_q <= 12'd128;
      lin_gain_q  <= 10'd51;
      ang_gain_q  <= 10'd307;
      pending_o   <= 0;
    end else begin
      // Results are retired before new inputs are predicted, so a result can
      // never be matched against the item that enters on the same edge.
      if (out_valid_i && out_ready_i) begin
        got.speed  = forward_speed_i;
        got.turn   = turn_rate_i;
        got.moving = moving_i;
        if (commands_due.size() == 0) begin
          if (failures < 10)
            $display("[%0t] unexpected command: speed %0d turn %0d moving %0b",
                     $time, got.speed, got.turn, got.moving);
          failures++;
        end else begin
          want = commands_due.pop_front();
          if (got.speed !== want.speed || got.turn !== want.turn
              || got.moving !== want.moving) begin
            if (failures < 10)
              $display("[%0t] command mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                       $time, want.speed, want.turn, want.moving,
                       got.speed, got.turn, got.moving);
            failures++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_STOP_DISTANCE: stop_dist_q <= cfg_data_i;
          REG_LINEAR_GAIN:   lin_gain_q  <= cfg_data_i[GAIN_W-1:0];
          REG_ANGULAR_GAIN:  ang_gain_q  <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        commands_due.push_back(predict_command(goal_x_i, goal_y_i, pose_x_i, pose_y_i,
                                               heading_i));
      pending_o    <= commands_due.size();
      fail_count_o <= failures;
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the go-to-goal velocity controller testbench: clock, reset, stimulus,
// register writes and the verdict. Depends on ggvc_pkg, ggvc_checker and the
// go_to_goal_velocity_controller_unit RTL.
module tb_top;
  import ggvc_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 8;
  // Reckoned from CORDIC_STAGES; sets the length of the final quiet period.
  localparam int LATENCY         = CORDIC_STAGES + 5;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int BURST_ITEMS     = 60;
  localparam int COORD_MAX       = 4095;
  localparam int HEADING_LIMIT   = 804;
  // Index beyond the register file; writes to it must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [COORD_W-1:0]       goal_x;
  logic [COORD_W-1:0]       goal_y;
  logic [COORD_W-1:0]       pose_x;
  logic [COORD_W-1:0]       pose_y;
  logic signed [HEAD_W-1:0] heading;
  logic                     out_valid;
  logic                     out_ready;
  logic [SPEED_W-1:0]       forward_speed;
  logic signed [TURN_W-1:0] turn_rate;
  logic                     moving;
  logic                     cfg_we;
  logic [1:0]               cfg_idx;
  logic [STOP_W-1:0]        cfg_data;

  int fail_count;
  int pending;

  // Idling switches, redrawn in stretches so that some runs go gap-free.
  bit sender_idle;
  bit receiver_idle;
  // Raised by the stimulus to make the receiver refuse results for a long
  // stretch; the receiver clears it once the hold-off is over.
  bit hold_off_req;
  // Stop distance currently programmed, used to aim random goals near the
  // stop circle so that both sides of the threshold are exercised.
  int cur_stop;

  go_to_goal_velocity_controller_unit #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRAC_BITS    (FRAC_BITS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .goal_x_i       (goal_x),
    .goal_y_i       (goal_y),
    .pose_x_i       (pose_x),
    .pose_y_i       (pose_y),
    .heading_i      (heading),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .forward_speed_o(forward_speed),
    .turn_rate_o    (turn_rate),
    .moving_o       (moving),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  ggvc_checker #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .goal_x_i       (goal_x),
    .goal_y_i       (goal_y),
    .pose_x_i       (pose_x),
    .pose_y_i       (pose_y),
    .heading_i      (heading),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .forward_speed_i(forward_speed),
    .turn_rate_i    (turn_rate),
    .moving_i       (moving),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The slowest correct run is roughly 450 items, each waiting out the longest
  // sender gap, the longest receiver stall and the full pipeline latency, plus
  // the long hold-off. The timeout leaves ample margin over it.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver. For every result it draws a stall, then holds ready high until a
  // transfer takes place. When asked, it first refuses results for a long
  // stretch so that the pipeline fills and back-pressure reaches the input.
  initial begin
    int stall;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall = receiver_idle ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one control tick and returns on the edge at which it is accepted.
  // Valid is left high so that a following item with no gap goes out at once;
  // it is only lowered when a gap is drawn or the sender goes quiet.
  task automatic send_item(input int gx, input int gy, input int px, input int py,
                           input int hd);
    int gap;
    gap = sender_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    goal_x   <= COORD_W'(gx);
    goal_y   <= COORD_W'(gy);
    pose_x   <= COORD_W'(px);
    pose_y   <= COORD_W'(py);
    heading  <= HEAD_W'(hd);
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every predicted command has been seen.
  // The first edge lets an item accepted just now reach the checker's count.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Programmes all three registers back to back and finishes with a write to
  // the unused index, which must leave them untouched. The gain writes carry
  // random junk above bit 9 that the block has to drop.
  task automatic set_config(input int stop, input int lin_gain, input int ang_gain);
    cur_stop = stop;
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_STOP_DISTANCE;
    cfg_data <= STOP_W'(stop);
    @(posedge clk);
    cfg_idx  <= REG_LINEAR_GAIN;
    cfg_data <= {2'($urandom_range(0, 3)), 10'(lin_gain)};
    @(posedge clk);
    cfg_idx  <= REG_ANGULAR_GAIN;
    cfg_data <= {2'($urandom_range(0, 3)), 10'(ang_gain)};
    @(posedge clk);
    cfg_idx  <= REG_UNUSED;
    cfg_data <= STOP_W'($urandom_range(0, 4095));
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Half of the random ticks put the goal within a couple of stop radii of the
  // pose, so that the threshold decision goes both ways; the rest span the
  // whole field. Clamping at the edges of the field makes the extreme
  // coordinates frequent. Most headings are legal, some use all eleven bits.
  task automatic send_random_item();
    int px, py, gx, gy, hd, reach, off;
    px = $urandom_range(0, COORD_MAX);
    py = $urandom_range(0, COORD_MAX);
    if ($urandom_range(0, 1) == 0) begin
      reach = 2 * cur_stop + 16;
      off   = $urandom_range(0, 2 * reach);
      gx    = px + off - reach;
      off   = $urandom_range(0, 2 * reach);
      gy    = py + off - reach;
      gx    = (gx < 0) ? 0 : ((gx > COORD_MAX) ? COORD_MAX : gx);
      gy    = (gy < 0) ? 0 : ((gy > COORD_MAX) ? COORD_MAX : gy);
    end else begin
      gx = $urandom_range(0, COORD_MAX);
      gy = $urandom_range(0, COORD_MAX);
    end
    if ($urandom_range(0, 3) != 0) begin
      hd = $urandom_range(0, 2 * HEADING_LIMIT);
      hd = hd - HEADING_LIMIT;
    end else begin
      hd = $urandom_range(0, 2047);
    end
    send_item(gx, gy, px, py, hd);
  endtask

  task automatic send_random_run(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) begin
        sender_idle   = ($urandom_range(0, 3) != 0);
        receiver_idle = ($urandom_range(0, 3) != 0);
      end
      send_random_item();
    end
  endtask

  // Back-to-back ticks while the receiver is held off: the pipeline fills up
  // and in_ready has to fall without any item being lost.
  task automatic send_into_stall();
    wait_drained();
    hold_off_req = 1'b1;
    sender_idle  = 1'b0;
    repeat (BURST_ITEMS) send_random_item();
  endtask

  initial begin
    in_valid      = 1'b0;
    goal_x        = '0;
    goal_y        = '0;
    pose_x        = '0;
    pose_y        = '0;
    heading       = '0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_STOP_DISTANCE;
    cfg_data      = '0;
    rst_n         = 1'b0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    hold_off_req  = 1'b0;
    cur_stop      = 128;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks with the reset values of the registers.
    send_item(0, 0, 0, 0, 0);                          // goal on the pose
    send_item(COORD_MAX, 0, COORD_MAX, 0, 0);          // goal on the pose, far corner
    send_item(COORD_MAX, COORD_MAX, 0, 0, HEADING_LIMIT);
    send_item(0, 0, COORD_MAX, COORD_MAX, -HEADING_LIMIT);
    send_item(0, COORD_MAX, COORD_MAX, 0, 0);          // second quadrant, start at +pi
    send_item(COORD_MAX, 0, 0, COORD_MAX, 0);          // fourth quadrant
    send_item(0, 1000, 2000, 1000, 100);               // straight behind: +pi
    send_item(0, 999, 2000, 1000, 0);                  // just below behind: -pi
    send_item(2000, 1000, 0, 1000, -100);              // straight ahead
    send_item(1000, 3000, 1000, 0, 0);                 // straight left
    send_item(1000, 0, 1000, 3000, 0);                 // straight right
    send_item(628, 500, 500, 500, 0);                  // exactly on the stop circle
    send_item(629, 500, 500, 500, 0);                  // one step outside it
    send_item(500, 372, 500, 500, 0);                  // on the circle, below
    send_item(590, 590, 500, 500, 0);                  // diagonal, just inside
    send_item(591, 591, 500, 500, 0);                  // diagonal, just outside
    send_item(3000, 2000, 100, 100, -1024);            // headings outside the legal range
    send_item(100, 3000, 2000, 100, 1023);
    send_item(100, 100, 3000, 3500, HEADING_LIMIT + 1);
    send_item(3500, 100, 100, 3000, -HEADING_LIMIT - 1);
    wait_drained();

    // Random phases, each under its own register setting; the first two are
    // the extremes. The sender pauses for a full drain in every phase, and
    // one phase includes the long receiver hold-off.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_config(0, 1023, 1023);
        1:       set_config(COORD_MAX, 0, 0);
        default: set_config($urandom_range(0, 700), $urandom_range(0, 1023),
                            $urandom_range(0, 1023));
      endcase
      send_random_run(30);
      if (phase == 2) send_into_stall();
      wait_drained();
      send_random_run(30);
      wait_drained();
    end

    // Quiet period to catch any stray result after the last expected one.
    repeat (LATENCY + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/ggvc_pkg.sv
src/ggvc_cell.sv
src/ggvc_scale.sv
src/go_to_goal_velocity_controller_unit.sv
bench/ggvc_checker.sv
bench/tb_top.sv
